// ===== rtl/lep_pkg.sv =====
package lep_pkg;

  // Operation codes carried on in_tuser
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_CUT = 1'b1;

  // Result beat layout
  localparam int LEN_W      = 7;
  localparam int OUT_DATA_W = 16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic clear;  // drop the search token held in the cell
    logic wr_en;  // store the broadcast key in the addressed cell
  } bcast_t;

endpackage

// ===== rtl/lep_cell.sv =====
module lep_cell
  import lep_pkg::*;
#(
  parameter int KEY_W = 16,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bcast_t           bc,
  input  logic [CNT_W-1:0] count,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [KEY_W-1:0] wr_key,
  input  logic             tok_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             tok_o,
  output logic [KEY_W-1:0] key_o,
  output logic             hit
);

  localparam logic [CNT_W-1:0] MyPos = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [KEY_W-1:0] point_r;
  logic             tok_r;
  logic [KEY_W-1:0] key_r;
  logic             live;

  // Entry counts as part of the path only below the fill count
  assign live = (MyPos < count);
  assign hit  = tok_i && live && (point_r == key_i);

  // Store a point when addressed
  always_ff @(posedge clk) begin
    if (bc.wr_en && (wr_idx == MyIdx)) begin
      point_r <= wr_key;
    end
  end

  // Advance the search token one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n || bc.clear) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  // Key travels alongside the token
  always_ff @(posedge clk) begin
    key_r <= key_i;
  end

  assign tok_o = tok_r;
  assign key_o = key_r;

endmodule

// ===== rtl/loop_erasing_path_store_core.sv =====
// Loop-erasing path store. Keeps an ordered path of up to MAX_POINTS grid points in a
// row of cells, one point per cell. Each beat on the input either adds a point (if the
// point is already on the path, everything after its first occurrence is erased and
// cycle_found is set; if the path is full the point is dropped and overflow is set) or
// cuts the path after the first matching point (no match leaves the path unchanged).
// One result beat comes back for every input beat. The query key walks down the cell
// row one cell per cycle, so a search ends at the first match or at the end of the
// path. The result beat is registered as the block leaves its emit state, and the input
// is ready again in the same cycle that this result beat is presented.
// A result still held by a stalled output keeps the next item in its last step until
// that beat is taken. One item is in work at a time.
// No clearing pass is needed after reset.
module loop_erasing_path_store_core
  import lep_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 8,
  localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // x_coord, y_coord, zero pad
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // cycle_found, point_found, overflow,
                                            // path_length, zero pad
);

  localparam int KEY_W = 2 * COORD_BITS;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_POINTS);

  state_t           state_r, state_nxt;
  logic [KEY_W-1:0] key_r;
  logic             op_r;
  logic             inject_r, inject_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             res_cyc_r, res_pf_r, res_ovf_r;
  logic             res_cyc_nxt, res_pf_nxt, res_ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  bcast_t           bc;
  logic [IDX_W-1:0] wr_idx;
  logic             tok_c [MAX_POINTS];
  logic [KEY_W-1:0] key_c [MAX_POINTS];
  logic [MAX_POINTS-1:0] hit_vec;
  logic             hit_any;
  logic             in_acc;
  logic             out_free;
  logic [CNT_W+LEN_W-1:0] len_ext;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign hit_any   = |hit_vec;
  assign wr_idx    = count_r[IDX_W-1:0];

  // Cell row
  assign tok_c[0] = inject_r;
  assign key_c[0] = key_r;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    if (i < MAX_POINTS - 1) begin : g_mid
      lep_cell #(
        .KEY_W(KEY_W), .IDX_W(IDX_W), .CNT_W(CNT_W), .IDX(i)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .bc    (bc),
        .count (count_r),
        .wr_idx(wr_idx),
        .wr_key(key_r),
        .tok_i (tok_c[i]),
        .key_i (key_c[i]),
        .tok_o (tok_c[i+1]),
        .key_o (key_c[i+1]),
        .hit   (hit_vec[i])
      );
    end else begin : g_last
      lep_cell #(
        .KEY_W(KEY_W), .IDX_W(IDX_W), .CNT_W(CNT_W), .IDX(i)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .bc    (bc),
        .count (count_r),
        .wr_idx(wr_idx),
        .wr_key(key_r),
        .tok_i (tok_c[i]),
        .key_i (key_c[i]),
        .tok_o (),
        .key_o (),
        .hit   (hit_vec[i])
      );
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    inject_nxt    = 1'b0;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    res_cyc_nxt   = res_cyc_r;
    res_pf_nxt    = res_pf_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    bc            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          inject_nxt = 1'b1;
          idx_nxt    = '0;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit_any) begin
          // First match: erase everything after it
          count_nxt   = idx_r + CNT_W'(1);
          res_pf_nxt  = 1'b1;
          res_cyc_nxt = (op_r == OP_ADD);
          res_ovf_nxt = 1'b0;
          bc.clear    = 1'b1;
          state_nxt   = ST_EMIT;
        end else if (idx_r == count_r) begin
          // No match on the path
          res_pf_nxt  = 1'b0;
          res_cyc_nxt = 1'b0;
          res_ovf_nxt = 1'b0;
          if (op_r == OP_ADD) begin
            if (count_r < MaxCnt) begin
              bc.wr_en  = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              res_ovf_nxt = 1'b1;
            end
          end
          bc.clear  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inject_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inject_r    <= inject_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  assign len_ext = {{LEN_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    res_cyc_r <= res_cyc_nxt;
    res_pf_r  <= res_pf_nxt;
    res_ovf_r <= res_ovf_nxt;
    if (in_acc) begin
      key_r <= {in_tdata[COORD_BITS-1:0], in_tdata[2*COORD_BITS-1:COORD_BITS]};
      op_r  <= in_tuser;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= {{(OUT_DATA_W - LEN_W - 3){1'b0}}, len_ext[LEN_W-1:0],
                     res_ovf_r, res_pf_r, res_cyc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell matched in a cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MaxCnt)
    else $error("path length beyond capacity");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (idx_r <= count_r))
    else $error("search ran past the path end");

  a_cycle_is_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || out_tdata[1]))
    else $error("cycle reported without a found point");

  a_hit_only_searching: assert property (@(posedge clk) disable iff (!rst_n)
    hit_any |-> (state_r == ST_SEARCH))
    else $error("stale token matched outside a search");
`endif

endmodule

// ===== bench/loop_erasing_path_store_checker.sv =====
module loop_erasing_path_store_checker
  import lep_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 8,
  parameter int IN_W       = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // x_coord, y_coord, zero pad
  input  logic                  in_tuser,   // operation
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // cycle_found, point_found, overflow,
                                            // path_length, zero pad
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [2*COORD_BITS-1:0] point_key_t;

  typedef struct packed {
    logic             cycle_found;
    logic             point_found;
    logic             overflow;
    logic [LEN_W-1:0] path_length;
  } move_result_t;

  // Shadow copy of the path held by the block
  point_key_t   path_keys [MAX_POINTS];
  int           path_len = 0;
  move_result_t results_due [$];

  // Apply one move to the shadow path and return the result it must produce
  function automatic move_result_t predict_move(input logic op,
                                                input logic [COORD_BITS-1:0] x,
                                                input logic [COORD_BITS-1:0] y);
    move_result_t r;
    point_key_t   key;
    int           hit;
    r   = '0;
    key = {x, y};
    hit = path_len;
    // find the first occurrence by scanning from the tail toward the head
    for (int i = path_len - 1; i >= 0; i--) begin
      if (path_keys[i] == key) hit = i;
    end
    if (hit < path_len) begin
      path_len      = hit + 1;
      r.point_found = 1'b1;
      r.cycle_found = (op == OP_ADD);
    end else if (op == OP_ADD) begin
      if (path_len < MAX_POINTS) begin
        path_keys[path_len] = key;
        path_len++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    r.path_length = path_len[LEN_W-1:0];
    return r;
  endfunction

  // Match result beats against the oldest prediction, then queue new predictions
  always @(posedge clk) begin
    move_result_t got;
    move_result_t want;
    if (!rst_n) begin
      path_len = 0;
      results_due.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.cycle_found = out_tdata[0];
        got.point_found = out_tdata[1];
        got.overflow    = out_tdata[2];
        got.path_length = out_tdata[3 +: LEN_W];
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected: tdata %h", out_tdata);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (got.cycle_found !== want.cycle_found) begin
            $error("cycle_found: expected %0d, got %0d", want.cycle_found, got.cycle_found);
            fail_count++;
          end
          if (got.point_found !== want.point_found) begin
            $error("point_found: expected %0d, got %0d", want.point_found, got.point_found);
            fail_count++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
            fail_count++;
          end
          if (got.path_length !== want.path_length) begin
            $error("path_length: expected %0d, got %0d", want.path_length, got.path_length);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        results_due.push_back(predict_move(in_tuser, in_tdata[0 +: COORD_BITS],
                                           in_tdata[COORD_BITS +: COORD_BITS]));
      end
      pending <= results_due.size();
    end
  end

endmodule

// ===== bench/loop_erasing_path_store_core_tb.sv =====
module loop_erasing_path_store_core_tb
  import lep_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 8;
  localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int MOVE_COUNT = 700;
  localparam int QUIET_LIMIT = 4000;
  localparam int IDLE_PCT   = 21;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = OP_ADD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int moves_sent = 0;
  bit steady = 1'b0;   // no idling on either side while set
  logic [2*COORD_BITS-1:0] recent_pts [$];

  loop_erasing_path_store_core #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  loop_erasing_path_store_checker #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS),
    .IN_W      (IN_W)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run when nothing moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("loop_erasing_path_store_core: mismatch");
    $finish;
  end

  // Offer one move beat, with a random gap ahead of it, and hold until accepted
  task automatic send_move(input logic op, input logic [COORD_BITS-1:0] x,
                           input logic [COORD_BITS-1:0] y);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    moves_sent++;
    recent_pts.push_back({x, y});
    if (recent_pts.size() > 96) void'(recent_pts.pop_front());
  endtask

  // Hold the input side until every outstanding result is back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Add a run of distinct points along one row
  task automatic walk_row(input int steps, input logic [COORD_BITS-1:0] x0,
                          input logic [COORD_BITS-1:0] y0);
    for (int i = 0; i < steps; i++) begin
      send_move(OP_ADD, x0 + i[COORD_BITS-1:0], y0);
    end
  endtask

  // Pick a point sent earlier, so that it likely still lies on the path
  function automatic logic [2*COORD_BITS-1:0] old_point();
    if (recent_pts.size() == 0) return '0;
    return recent_pts[$urandom_range(recent_pts.size() - 1)];
  endfunction

  initial begin
    int pick;
    logic [2*COORD_BITS-1:0] pt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: cut on empty path, corner points, loop erasure, cuts with and without match
    send_move(OP_CUT, 8'h00, 8'h00);
    send_move(OP_ADD, 8'h00, 8'h00);
    send_move(OP_ADD, 8'hff, 8'hff);
    send_move(OP_ADD, 8'hff, 8'h00);
    send_move(OP_ADD, 8'h00, 8'hff);
    send_move(OP_ADD, 8'h00, 8'h00);
    send_move(OP_ADD, 8'hff, 8'hff);
    send_move(OP_ADD, 8'haa, 8'h55);
    send_move(OP_ADD, 8'h55, 8'haa);
    send_move(OP_CUT, 8'haa, 8'h55);
    send_move(OP_CUT, 8'h12, 8'h34);
    send_move(OP_ADD, 8'h55, 8'haa);
    send_move(OP_ADD, 8'haa, 8'h55);
    send_move(OP_CUT, 8'h00, 8'h00);
    send_move(OP_ADD, 8'h00, 8'h00);
    send_move(OP_CUT, 8'h00, 8'h00);
    send_move(OP_ADD, 8'h01, 8'h00);
    send_move(OP_ADD, 8'h00, 8'h01);
    send_move(OP_CUT, 8'hff, 8'hff);
    wait_drain();

    // Fill the path past its end on a row unused so far: full path, overflow
    walk_row(MAX_POINTS + 4, 8'h00, 8'h80);
    send_move(OP_ADD, 8'h10, 8'h80);
    send_move(OP_CUT, 8'h00, 8'h80);

    // Random moves: mostly walks with revisits and cuts, some noise
    while (moves_sent < MOVE_COUNT) begin
      steady = (moves_sent >= 300 && moves_sent < 420);
      if (moves_sent >= 500 && moves_sent < 510) wait_drain();
      pick = $urandom_range(99);
      if (pick < 40) begin
        walk_row($urandom_range(10, 1), 8'($urandom), 8'($urandom));
      end else if (pick < 60) begin
        pt = old_point();
        send_move(OP_ADD, pt[COORD_BITS +: COORD_BITS], pt[0 +: COORD_BITS]);
      end else if (pick < 75) begin
        pt = old_point();
        send_move(OP_CUT, pt[COORD_BITS +: COORD_BITS], pt[0 +: COORD_BITS]);
      end else if (pick < 85) begin
        send_move(OP_CUT, 8'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        send_move(1'($urandom), 8'($urandom_range(3)), 8'($urandom_range(3)));
      end else begin
        walk_row(MAX_POINTS + $urandom_range(6, 1), 8'($urandom), 8'($urandom));
      end
    end
    steady = 1'b0;

    // Drain and let the block settle before the verdict
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (MAX_POINTS + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("loop_erasing_path_store_core: match");
    end else begin
      $display("loop_erasing_path_store_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lep_pkg.sv
rtl/lep_cell.sv
rtl/loop_erasing_path_store_core.sv
bench/loop_erasing_path_store_checker.sv
bench/loop_erasing_path_store_core_tb.sv
